// ===== hw/rtl/ttce_pkg.sv =====
// shared types and constants for the text terminal cursor engine
package ttce_pkg;

    // field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int FUNC_W = 2;
    localparam int TAB_W  = 4;

    // default screen geometry
    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    // attribute after reset
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // tab stop spacing
    localparam logic [TAB_W-1:0] TAB_STOP = 4'd8;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SETPOS = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // input beat
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  new_col;
        logic [ROW_W-1:0]  new_row;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic              write_cell;
        logic [COL_W-1:0]  cell_col;
        logic [ROW_W-1:0]  cell_row;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic              scroll_after;
        logic              clear_screen;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic step;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic has_res;
        logic out_last;
    } t_dp_status;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_HOLD = 4'b0100,
        S_PEND = 4'b1000
    } t_state;

endpackage

// ===== hw/rtl/ttce_ctrl.sv =====
// controller state machine for the text terminal cursor engine
module ttce_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  ttce_pkg::t_dp_status i_status,
    output ttce_pkg::t_ctrl_cmd  o_cmd
);
    import ttce_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.load_in = 1'b0;
        o_cmd.step    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = i_status.has_res ? S_HOLD : S_IDLE;
            end
            S_HOLD: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_status.out_last;
                o_cmd.load_in = i_status.out_last & i_in_valid;
                if (i_out_ready) begin
                    if (!i_status.out_last || i_in_valid) begin
                        n_state = S_STEP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (i_status.out_last && i_in_valid) begin
                    n_state = S_PEND;
                end
            end
            S_PEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_STEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ttce_datapath.sv =====
// cursor state, input holding register and result register
module ttce_datapath #(
    parameter int COLS = ttce_pkg::DEF_COLS,
    parameter int ROWS = ttce_pkg::DEF_ROWS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ttce_pkg::t_in_item    i_in_item,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data,
    input  ttce_pkg::t_ctrl_cmd   i_cmd,
    output ttce_pkg::t_dp_status  o_status,
    output ttce_pkg::t_out_item   o_out_item
);
    import ttce_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    t_in_item          r_in;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ATTR_W-1:0] r_attr;
    logic [TAB_W-1:0]  r_tab;
    t_out_item         r_out;

    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [TAB_W-1:0]  n_tab;
    t_out_item         n_out;
    logic              has_res;

    // one result from the held operation and the current cursor
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_tab   = r_tab;
        has_res = 1'b1;
        n_out   = '0;
        n_out.cell_attr = r_attr;
        n_out.last      = 1'b1;
        case (r_in.func)
            FUNC_CLEAR: begin
                n_col = '0;
                n_row = '0;
                n_out.clear_screen = 1'b1;
            end
            FUNC_SETPOS: begin
                n_col = (r_in.new_col > LAST_COL) ? LAST_COL : r_in.new_col;
                n_row = (r_in.new_row > LAST_ROW) ? LAST_ROW : r_in.new_row;
            end
            FUNC_PUT: begin
                case (r_in.char_code)
                    CH_LF: begin
                        n_col = '0;
                        if (r_row >= LAST_ROW) begin
                            n_row = LAST_ROW;
                            n_out.scroll_after = 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end
                    CH_CR: begin
                        n_col = '0;
                    end
                    CH_BS: begin
                        if (r_col != '0) begin
                            n_col = r_col - 1'b1;
                            n_out.write_cell = 1'b1;
                            n_out.cell_col   = r_col - 1'b1;
                            n_out.cell_row   = r_row;
                            n_out.cell_char  = CH_SPACE;
                        end else begin
                            has_res = 1'b0;
                        end
                    end
                    default: begin
                        // any other byte or one space of a tab
                        n_out.write_cell = 1'b1;
                        n_out.cell_col   = r_col;
                        n_out.cell_row   = r_row;
                        if (r_in.char_code == CH_TAB) begin
                            n_out.cell_char = CH_SPACE;
                            n_tab           = r_tab - 1'b1;
                            n_out.last      = (r_tab == TAB_W'(1));
                        end else begin
                            n_out.cell_char = r_in.char_code;
                        end
                        if (r_col >= LAST_COL) begin
                            n_col = '0;
                            if (r_row >= LAST_ROW) begin
                                n_row = LAST_ROW;
                                n_out.scroll_after = 1'b1;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                endcase
            end
            default: begin
                has_res = 1'b0;
            end
        endcase
        n_out.cursor_col = n_col;
        n_out.cursor_row = n_row;
    end

    // cursor, tab count and attribute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_attr <= ATTR_RESET;
            r_tab  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.load_in) begin
                r_tab <= TAB_STOP - {1'b0, r_col[2:0]};
            end else if (i_cmd.step && has_res) begin
                r_tab <= n_tab;
            end
            if (i_cmd.step && has_res) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // input beat and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
        if (i_cmd.step && has_res) begin
            r_out <= n_out;
        end
    end

    assign o_status.has_res  = has_res;
    assign o_status.out_last = r_out.last;
    assign o_out_item        = r_out;

endmodule

// ===== hw/rtl/text_terminal_cursor_engine.sv =====
// top level of the text terminal cursor engine
//
// Input channel (i_in_valid / o_in_ready, i_in_item) takes one operation per
// beat: put a character, clear the screen or set the cursor position.
// Output channel (o_out_valid / i_out_ready, o_out_item) gives frame-store
// commands: one cell write, a scroll-up flag, a clear flag, the cursor after
// the command and a last flag on the final beat of each operation.
// The input beat is registered; the controller then computes the result in its
// step state, registers it and offers it in the hold state. One result is given
// per step/hold loop of the controller; a tab gives one to eight results.
// Operations with no result (backspace at column zero, unused code) give no
// output beat and return to idle.
// The next input beat is taken while the last result of the previous one is
// still held, so a new operation is taken before the previous one is through.
// A stalled output holds its beat; while it waits at most one more input beat
// is taken, and only when the held beat is the last of its operation.
// i_cfg_we writes the attribute byte; write it only while the block is idle.
// Reset (synchronous, active low) puts the cursor at column 0, row 0 and the
// attribute at 0x07, and drops any operation in flight.
module text_terminal_cursor_engine #(
    parameter int COLS = ttce_pkg::DEF_COLS,
    parameter int ROWS = ttce_pkg::DEF_ROWS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ttce_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ttce_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data
);
    import ttce_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // sequencing
    ttce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // cursor arithmetic and result register
    ttce_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule

// ===== tb/ttce_cmd_checker.sv =====
// checker that predicts and compares frame-store commands of the text terminal cursor engine
`timescale 1ns / 100ps
module ttce_cmd_checker #(
    parameter int COLS = ttce_pkg::DEF_COLS,
    parameter int ROWS = ttce_pkg::DEF_ROWS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  ttce_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  ttce_pkg::t_out_item i_out_item,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_done,
    output int                  o_pending,
    output int                  o_fail_count
);
    import ttce_pkg::*;

    // own copy of cursor and attribute
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [ATTR_W-1:0] attr;

    // frame-store commands still to come out, oldest first
    t_out_item pending_cmds[$];
    int        errors = 0;
    bit        done_seen = 1'b0;

    // one command with the cursor as it stands now
    function automatic t_out_item make_cmd(logic wr, logic [COL_W-1:0] col,
                                           logic [ROW_W-1:0] row, logic [CHAR_W-1:0] ch,
                                           logic scroll, logic clr);
        t_out_item cmd;
        cmd.write_cell   = wr;
        cmd.cell_col     = wr ? col : '0;
        cmd.cell_row     = wr ? row : '0;
        cmd.cell_char    = wr ? ch : '0;
        cmd.cell_attr    = attr;
        cmd.scroll_after = scroll;
        cmd.clear_screen = clr;
        cmd.cursor_col   = cur_col;
        cmd.cursor_row   = cur_row;
        cmd.last         = 1'b0;
        return cmd;
    endfunction

    // column 0 of the next row; returns 1 when the screen has to scroll
    function automatic logic next_row();
        cur_col = '0;
        if (int'(cur_row) + 1 >= ROWS) begin
            cur_row = ROW_W'(ROWS - 1);
            return 1'b1;
        end
        cur_row = cur_row + 1'b1;
        return 1'b0;
    endfunction

    // write at the cursor, advance and wrap
    function automatic t_out_item put_cell(logic [CHAR_W-1:0] ch);
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             scroll;
        col    = cur_col;
        row    = cur_row;
        scroll = 1'b0;
        if (int'(cur_col) + 1 >= COLS) begin
            scroll = next_row();
        end else begin
            cur_col = cur_col + 1'b1;
        end
        return make_cmd(1'b1, col, row, ch, scroll, 1'b0);
    endfunction

    // commands caused by one operation, appended to the expected list
    function automatic void predict_commands(t_in_item op);
        t_out_item burst[$];
        t_out_item final_cmd;
        logic      scroll;
        int        spaces;
        case (op.func)
            FUNC_CLEAR: begin
                cur_col = '0;
                cur_row = '0;
                burst.push_back(make_cmd(1'b0, '0, '0, '0, 1'b0, 1'b1));
            end
            FUNC_SETPOS: begin
                cur_col = (int'(op.new_col) > COLS - 1) ? COL_W'(COLS - 1) : op.new_col;
                cur_row = (int'(op.new_row) > ROWS - 1) ? ROW_W'(ROWS - 1) : op.new_row;
                burst.push_back(make_cmd(1'b0, '0, '0, '0, 1'b0, 1'b0));
            end
            FUNC_PUT: begin
                case (op.char_code)
                    CH_LF: begin
                        scroll = next_row();
                        burst.push_back(make_cmd(1'b0, '0, '0, '0, scroll, 1'b0));
                    end
                    CH_CR: begin
                        cur_col = '0;
                        burst.push_back(make_cmd(1'b0, '0, '0, '0, 1'b0, 1'b0));
                    end
                    CH_TAB: begin
                        // spaces up to the next tab stop, counting on across a wrap
                        spaces = int'(TAB_STOP) - int'(cur_col) % int'(TAB_STOP);
                        while (spaces > 0 && burst.size() < int'(TAB_STOP)) begin
                            burst.push_back(put_cell(CH_SPACE));
                            spaces--;
                        end
                    end
                    CH_BS: begin
                        // nothing at column zero
                        if (cur_col != '0) begin
                            cur_col = cur_col - 1'b1;
                            burst.push_back(make_cmd(1'b1, cur_col, cur_row, CH_SPACE,
                                                     1'b0, 1'b0));
                        end
                    end
                    default: begin
                        burst.push_back(put_cell(op.char_code));
                    end
                endcase
            end
            default: begin
            end
        endcase
        // flag the final command of this operation
        if (burst.size() > 0) begin
            final_cmd = burst.pop_back();
            final_cmd.last = 1'b1;
            burst.push_back(final_cmd);
        end
        foreach (burst[i]) pending_cmds.push_back(burst[i]);
    endfunction

    function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // compare one output beat with the oldest expected command
    function automatic void check_beat(t_out_item got);
        t_out_item want;
        if (pending_cmds.size() == 0) begin
            $display("%0t ns: output beat expected none got %h", $time, got);
            errors++;
        end else begin
            want = pending_cmds.pop_front();
            cmp_field("write_cell", 8'(want.write_cell), 8'(got.write_cell));
            cmp_field("cell_col", 8'(want.cell_col), 8'(got.cell_col));
            cmp_field("cell_row", 8'(want.cell_row), 8'(got.cell_row));
            cmp_field("cell_char", want.cell_char, got.cell_char);
            cmp_field("cell_attr", want.cell_attr, got.cell_attr);
            cmp_field("scroll_after", 8'(want.scroll_after), 8'(got.scroll_after));
            cmp_field("clear_screen", 8'(want.clear_screen), 8'(got.clear_screen));
            cmp_field("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
            cmp_field("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
            cmp_field("last", 8'(want.last), 8'(got.last));
        end
    endfunction

    // watch both channels and the attribute port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_col = '0;
            cur_row = '0;
            attr    = ATTR_RESET;
            pending_cmds.delete();
        end else begin
            if (i_cfg_we) attr = i_cfg_data;
            if (i_in_valid && i_in_ready) predict_commands(i_in_item);
            if (i_out_valid && i_out_ready) check_beat(i_out_item);
            // anything still expected at the end never came
            if (i_done && !done_seen) begin
                done_seen = 1'b1;
                if (pending_cmds.size() > 0) begin
                    $display("%0t ns: expected %0d more output beats got none",
                             $time, pending_cmds.size());
                    errors += pending_cmds.size();
                end
            end
        end
        o_pending    <= pending_cmds.size();
        o_fail_count <= errors;
    end

endmodule

// ===== tb/tb.sv =====
// testbench top for the text terminal cursor engine: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb;
    import ttce_pkg::*;

    localparam int COLS = DEF_COLS;
    localparam int ROWS = DEF_ROWS;

    // operation code the block ignores
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int QUIET_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 6;
    localparam int HALF_PHASE   = 32;
    localparam int CALM_ITEMS   = 40;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_data  = '0;
    logic       done      = 1'b0;
    logic       idle_en   = 1'b1;
    bit         timed_out = 1'b0;
    int         cmds_pending;
    int         fail_count;

    int unsigned stall_left = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    text_terminal_cursor_engine #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    ttce_cmd_checker #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_done      (done),
        .o_pending   (cmds_pending),
        .o_fail_count(fail_count)
    );

    // frame-store side stalls in bursts
    always @(posedge clk) begin
        if (!idle_en) begin
            stall_left = 0;
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // unused fields carry random bits
    function automatic t_in_item noise_op();
        logic [31:0] bits;
        bits = $urandom;
        return bits[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item put_op(logic [CHAR_W-1:0] ch);
        t_in_item op;
        op           = noise_op();
        op.func      = FUNC_PUT;
        op.char_code = ch;
        return op;
    endfunction

    function automatic t_in_item setpos_op(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        t_in_item op;
        op         = noise_op();
        op.func    = FUNC_SETPOS;
        op.new_col = col;
        op.new_row = row;
        return op;
    endfunction

    function automatic t_in_item clear_op();
        t_in_item op;
        op      = noise_op();
        op.func = FUNC_CLEAR;
        return op;
    endfunction

    // mostly text with control characters, positions biased toward the edges
    function automatic t_in_item rand_op();
        int       pick;
        t_in_item op;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            op = put_op(8'($urandom_range(32, 126)));
        end else if (pick < 56) begin
            op = put_op(8'($urandom_range(0, 255)));
        end else if (pick < 64) begin
            op = put_op(CH_LF);
        end else if (pick < 69) begin
            op = put_op(CH_CR);
        end else if (pick < 77) begin
            op = put_op(CH_TAB);
        end else if (pick < 84) begin
            op = put_op(CH_BS);
        end else if (pick < 95) begin
            op = setpos_op($urandom_range(0, 1) ? 7'($urandom_range(COLS - 12, 127))
                                                : 7'($urandom_range(0, 127)),
                           $urandom_range(0, 1) ? 5'($urandom_range(ROWS - 5, 31))
                                                : 5'($urandom_range(0, 31)));
        end else if (pick < 97) begin
            op = clear_op();
        end else begin
            op      = noise_op();
            op.func = FUNC_UNUSED;
        end
        return op;
    endfunction

    // one input beat, with an optional gap before it
    task automatic send_op(t_in_item op);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= op;
        do @(posedge clk); while (!in_ready);
    endtask

    // hold the input until every expected command is out and the block settles
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cmds_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_attr(logic [7:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count);
        int       sent;
        t_in_item op;
        sent = 0;
        while (sent < count) begin
            op = rand_op();
            send_op(op);
            if (op.func != FUNC_UNUSED) sent++;
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        fork
            begin : stimulus
                @(posedge clk);
                // directed: attribute at its reset value
                send_op(put_op(8'h41));
                send_op(put_op(8'hFF));
                send_op(put_op(8'h00));
                send_op(put_op(CH_BS));
                send_op(put_op(CH_TAB));
                send_op(put_op(CH_TAB));
                send_op(put_op(CH_CR));
                send_op(put_op(CH_BS));
                send_op(t_in_item'{FUNC_UNUSED, 8'hFF, 7'h7F, 5'h1F});
                // saturation to the bottom right, then wrap with scroll
                send_op(setpos_op(7'h7F, 5'h1F));
                send_op(put_op(8'h5A));
                send_op(put_op(CH_LF));
                // tab that runs into the end of the last row
                send_op(setpos_op(7'd76, 5'd24));
                send_op(put_op(CH_TAB));
                send_op(setpos_op(7'd79, 5'd0));
                send_op(put_op(8'h7E));
                send_op(setpos_op(7'(COLS), 5'(ROWS)));
                send_op(setpos_op(7'd0, 5'd23));
                send_op(put_op(CH_LF));
                send_op(clear_op());
                send_op(setpos_op(7'd5, 5'd3));
                send_op(put_op(CH_BS));
                // random phases with different attributes
                wait_drained();
                write_attr(8'h00);
                run_random(HALF_PHASE);
                wait_drained();
                run_random(HALF_PHASE);
                wait_drained();
                write_attr(8'($urandom_range(1, 254)));
                run_random(HALF_PHASE);
                wait_drained();
                run_random(HALF_PHASE);
                wait_drained();
                write_attr(8'hFF);
                run_random(2 * HALF_PHASE - CALM_ITEMS);
                idle_en <= 1'b0;
                run_random(CALM_ITEMS);
                wait_drained();
            end
            begin : watchdog
                int quiet;
                quiet = 0;
                while (quiet < QUIET_LIMIT) begin
                    @(posedge clk);
                    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                        quiet = 0;
                    end else begin
                        quiet++;
                    end
                end
                timed_out = 1'b1;
            end
        join_any
        disable fork;
        done <= 1'b1;
        repeat (2) @(posedge clk);
        if (!timed_out && fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
